>>> rtl/hlf_pkg.sv
// Shared types and constants for the header line folder.
package hlf_pkg;

  // Width of the line limit register and of the segment length field.
  localparam int unsigned LIMIT_W = 16;

  // Default line position width.
  localparam int unsigned POS_WIDTH_DEF = 16;

  // Reset value of the line limit register.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd78;

  // Characters of the fold sequence.
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;

  // Request codes of an input beat.
  typedef enum logic [1:0] {
    REQ_FOLDABLE = 2'd0,
    REQ_BLOCK    = 2'd1,
    REQ_CONSUME  = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_type_t;

  // Configuration register indexes.
  typedef enum logic {
    CFG_LINE_LIMIT   = 1'b0,
    CFG_FOLD_WITH_CR = 1'b1
  } cfg_index_t;

  // Which result of an item the output stage is presenting.
  typedef enum logic [1:0] {
    PH_CR   = 2'd0,
    PH_LF   = 2'd1,
    PH_TAB  = 2'd2,
    PH_BYTE = 2'd3
  } phase_t;

  // Input beat payload.
  typedef struct packed {
    req_type_t         req_type;
    logic [7:0]        data_byte;
    logic              starts_segment;
    logic              prefold;
    logic [LIMIT_W-1:0] segment_length;
  } in_item_t;

  // Result beat payload.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_fold_byte;
    logic       last_of_run;
  } out_item_t;

endpackage

>>> rtl/header_line_folder_unit.sv
// Top level of the header line folder: fold decision, line position and output stage.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data) takes one request per beat:
//   a foldable text byte, an unbreakable block byte, a consume or a clear.
//   The result channel (out_valid, out_stall, out_data) returns the text byte,
//   preceded by a fold sequence (CR if enabled, LF, TAB) when the line is full.
//   Consume and clear beats only update the line position and give no result.
//   The first result of an item is valid in the cycle after the item is
//   accepted. Items flow at one item per cycle when no fold is inserted and
//   out_stall is low; a fold first sends LF TAB, or CR LF TAB, from the single
//   output register that sends one result beat per cycle while not stalled.
//   A new item is accepted in the same cycle that the last result of the
//   previous item is taken, so unfolded bytes stream without gaps.
//   When the receiver stalls, the result beat holds and in_stall rises until
//   the final result of the pending item leaves.
//   Reset (rst_n low at a clock edge) clears the line position and the output
//   stage, sets the line limit to 78 and selects LF-only folds.
//   The cfg_ port writes line_limit (index 0) or fold_with_cr (index 1); the
//   user writes it only while the block is idle, which the block does not enforce.
module header_line_folder_unit
  import hlf_pkg::*;
#(
  parameter int unsigned POS_WIDTH = POS_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration port.
  input  logic               cfg_we,
  input  cfg_index_t         cfg_index,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  // Input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data
);

  // Compare width wide enough that position plus length never wraps.
  localparam int unsigned CW = ((POS_WIDTH > LIMIT_W) ? POS_WIDTH : LIMIT_W) + 1;
  localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic [LIMIT_W-1:0]   limit_r;
  logic                 cr_r;
  logic                 busy_r, busy_nxt;
  phase_t               phase_r, phase_nxt;
  logic [7:0]           byte_r, byte_nxt;

  logic                 accept_in;
  logic                 take_out;
  logic                 last_beat;
  logic                 emits;
  logic                 fold;
  logic [CW-1:0]        pos_ext;
  logic [CW-1:0]        limit_ext;
  logic [CW-1:0]        sum_len;
  logic [POS_WIDTH-1:0] base_pos;
  logic [POS_WIDTH-1:0] inc_pos;
  logic [POS_WIDTH-1:0] sat_sum;
  phase_t               start_phase;

  // Handshake.
  assign take_out  = busy_r && !out_stall;
  assign last_beat = (phase_r == PH_BYTE);
  assign in_stall  = busy_r && !(take_out && last_beat);
  assign accept_in = in_valid && !in_stall;
  assign emits     = in_data.req_type inside {REQ_FOLDABLE, REQ_BLOCK};

  // Fold decision against the current line position.
  assign pos_ext   = CW'(pos_r);
  assign limit_ext = CW'(limit_r);
  assign sum_len   = pos_ext + CW'(in_data.segment_length);

  always_comb begin
    fold = 1'b0;
    case (in_data.req_type)
      REQ_FOLDABLE: begin
        fold = (pos_ext >= limit_ext) && (!in_data.starts_segment || in_data.prefold);
      end
      REQ_BLOCK: begin
        fold = in_data.starts_segment && in_data.prefold && (pos_r != '0) &&
               (sum_len > limit_ext);
      end
      default: begin
        fold = 1'b0;
      end
    endcase
  end

  // Position arithmetic, saturating at the top of the range.
  assign base_pos = fold ? POS_WIDTH'(1) : pos_r;
  assign inc_pos  = (base_pos == POS_MAX) ? base_pos : base_pos + POS_WIDTH'(1);
  assign sat_sum  = (sum_len > CW'(POS_MAX)) ? POS_MAX : sum_len[POS_WIDTH-1:0];

  always_comb begin
    pos_nxt = pos_r;
    if (accept_in) begin
      case (in_data.req_type)
        REQ_FOLDABLE, REQ_BLOCK: pos_nxt = inc_pos;
        REQ_CONSUME:             pos_nxt = sat_sum;
        REQ_CLEAR:               pos_nxt = '0;
        default:                 pos_nxt = pos_r;
      endcase
    end
  end

  // First result of a new item.
  always_comb begin
    if (!fold) begin
      start_phase = PH_BYTE;
    end else if (cr_r) begin
      start_phase = PH_CR;
    end else begin
      start_phase = PH_LF;
    end
  end

  // Output stage sequencing.
  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    byte_nxt  = byte_r;
    if (accept_in && emits) begin
      busy_nxt  = 1'b1;
      phase_nxt = start_phase;
      byte_nxt  = in_data.data_byte;
    end else if (take_out) begin
      case (phase_r)
        PH_CR:   phase_nxt = PH_LF;
        PH_LF:   phase_nxt = PH_TAB;
        PH_TAB:  phase_nxt = PH_BYTE;
        PH_BYTE: busy_nxt  = 1'b0;
        default: phase_nxt = PH_BYTE;
      endcase
    end
  end

  // Result beat payload.
  always_comb begin
    out_data = '0;
    case (phase_r)
      PH_CR:   out_data.out_byte = CH_CR;
      PH_LF:   out_data.out_byte = CH_LF;
      PH_TAB:  out_data.out_byte = CH_TAB;
      PH_BYTE: out_data.out_byte = byte_r;
      default: out_data.out_byte = byte_r;
    endcase
    out_data.is_fold_byte = !last_beat;
    out_data.last_of_run  = last_beat;
  end

  assign out_valid = busy_r;

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      limit_r <= LIMIT_RESET;
      cr_r    <= 1'b0;
      busy_r  <= 1'b0;
      phase_r <= PH_BYTE;
    end else begin
      pos_r   <= pos_nxt;
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LINE_LIMIT:   limit_r <= cfg_wdata;
          CFG_FOLD_WITH_CR: cr_r    <= cfg_wdata[0];
          default:          limit_r <= limit_r;
        endcase
      end
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule
